@@ hw/rtl/i2cms_pkg.sv @@
// Shared types, codes and constants of the I2C master bit sequencer.
`default_nettype none

package i2cms_pkg;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_SEND  = 3'd3,
    OP_RECV  = 3'd4,
    OP_ACK   = 3'd5,
    OP_RDACK = 3'd6
  } op_e_t;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd10;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_line;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } res_t;

  typedef struct packed {
    logic        scl;
    logic        sda;
    op_e_t       op;
    logic [4:0]  idx;
    logic [15:0] cnt;
    logic [7:0]  tx;
    logic [7:0]  rx;
    logic        ack;
  } state_t;

  // Number of pin phases in each operation.
  function automatic logic [4:0] op_len(op_e_t op);
    logic [4:0] n;
    case (op)
      OP_START: n = 5'd4;
      OP_STOP:  n = 5'd4;
      OP_SEND:  n = 5'd16;
      OP_RECV:  n = 5'd18;
      OP_ACK:   n = 5'd3;
      OP_RDACK: n = 5'd3;
      default:  n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/i2cms_if.sv @@
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic       ack_level;
  logic       sda_line;

  modport source (output valid, command, tx_byte, ack_level, sda_line, input ready);
  modport sink (input valid, command, tx_byte, ack_level, sda_line, output ready);
endinterface

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_seen,
                  input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_seen,
                output ready);
endinterface

`default_nettype wire

@@ hw/rtl/i2cms_step.sv @@
// Next-state and result logic for one tick of the bit sequencer.
`default_nettype none

module i2cms_step (
  input  var i2cms_pkg::state_t st,
  input  var i2cms_pkg::req_t   req,
  input  wire logic [15:0]      phase_ticks,
  output i2cms_pkg::state_t     st_nxt,
  output i2cms_pkg::res_t       res
);

  // Pin change at the beginning of phase idx of the current operation.
  function automatic i2cms_pkg::state_t enter_phase(i2cms_pkg::state_t s, logic [4:0] idx);
    i2cms_pkg::state_t r;
    r = s;
    case (s.op)
      i2cms_pkg::OP_START, i2cms_pkg::OP_STOP: begin
        if (idx == 5'd0) r.scl = 1'b0;
        else if (idx == 5'd1) r.sda = (s.op == i2cms_pkg::OP_START);
        else if (idx == 5'd2) r.scl = 1'b1;
        else r.sda = (s.op == i2cms_pkg::OP_STOP);
      end
      i2cms_pkg::OP_SEND: begin
        if (!idx[0]) begin
          r.scl = 1'b0;
        end else begin
          r.scl = 1'b1;
          r.sda = s.tx[7];
          r.tx  = {s.tx[6:0], 1'b0};
        end
      end
      i2cms_pkg::OP_RECV: begin
        if (idx == 5'd0) r.scl = 1'b0;
        else if (idx == 5'd1) r.sda = 1'b1;
        else r.scl = !idx[0];
      end
      i2cms_pkg::OP_ACK, i2cms_pkg::OP_RDACK: begin
        if (idx == 5'd0) begin
          r.scl = 1'b0;
        end else if (idx == 5'd1) begin
          if (s.op == i2cms_pkg::OP_ACK) begin
            r.sda = s.tx[7];
            r.tx  = {s.tx[6:0], 1'b0};
          end else begin
            r.sda = 1'b1;
          end
        end else begin
          r.scl = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  i2cms_pkg::state_t a;
  i2cms_pkg::state_t b;
  logic              start_ok;
  logic              phase_end;
  logic              done;
  logic [15:0]       len;
  logic [16:0]       cnt_inc;
  logic [4:0]        idx_inc;

  always_comb begin
    a = st;
    start_ok = (st.op == i2cms_pkg::OP_IDLE)
            && (req.command >= 3'(i2cms_pkg::OP_START))
            && (req.command <= 3'(i2cms_pkg::OP_RDACK));
    if (start_ok) begin
      a.op  = i2cms_pkg::op_e_t'(req.command);
      a.idx = 5'd0;
      a.cnt = 16'd0;
      if (a.op == i2cms_pkg::OP_SEND) a.tx = req.tx_byte;
      else if (a.op == i2cms_pkg::OP_ACK) a.tx = {req.ack_level, 7'd0};
      a = enter_phase(a, 5'd0);
    end

    len       = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    cnt_inc   = {1'b0, a.cnt} + 17'd1;
    phase_end = (cnt_inc >= {1'b0, len});
    idx_inc   = a.idx + 5'd1;

    b    = a;
    done = 1'b0;
    if (a.op != i2cms_pkg::OP_IDLE) begin
      if (phase_end) begin
        // sample SDA at the end of SCL-high phases of the reading operations
        if (a.op == i2cms_pkg::OP_RECV && a.idx >= 5'd2 && !a.idx[0]) begin
          b.rx = {a.rx[6:0], req.sda_line};
        end else if (a.op == i2cms_pkg::OP_RDACK && a.idx == 5'd2) begin
          b.ack = req.sda_line;
        end
        b.idx = idx_inc;
        b.cnt = 16'd0;
        if (idx_inc >= i2cms_pkg::op_len(a.op)) begin
          b.op  = i2cms_pkg::OP_IDLE;
          b.idx = 5'd0;
          done  = 1'b1;
        end else begin
          b = enter_phase(b, idx_inc);
        end
      end else begin
        b.cnt = cnt_inc[15:0];
      end
    end

    st_nxt       = b;
    res.scl_out  = b.scl;
    res.sda_out  = b.sda;
    res.busy_res = (b.op != i2cms_pkg::OP_IDLE);
    res.done_res = done;
    res.rx_byte  = b.rx;
    res.ack_seen = b.ack;
  end

endmodule

`default_nettype wire

@@ hw/rtl/i2c_master_bit_sequencer.sv @@
// Top level of the I2C master bit sequencer: input, state and result registers.
//
//   channel  | dir | handshake        | payload
//   in_chan  | in  | valid/ready      | command, tx_byte, ack_level, sda_line (one tick)
//   out_chan | out | valid/ready      | scl_out, sda_out, busy_res, done_res, rx_byte, ack_seen
//   cfg_     | in  | cfg_we, no ready | cfg_wdata = phase_ticks
//
// One request per clock while the result is not stalled; each gives one result, registered
// in the input register, then passed through the step logic into the result register.
// Sequencer state advances when a request moves from the input register to the result register.
// A stalled result holds the result register; an empty input register still takes one request.
// Reset: synchronous, clears pipeline valids and sequencer state, phase_ticks back to 10.
`default_nettype none

module i2c_master_bit_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  i2cms_in_if.sink         in_chan,
  i2cms_out_if.source      out_chan,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0]       phase_ticks_r;
  logic              s1_v_r;
  i2cms_pkg::req_t   s1_r;
  i2cms_pkg::state_t st_r;
  i2cms_pkg::state_t st_nxt;
  logic              out_v_r;
  i2cms_pkg::res_t   out_r;
  i2cms_pkg::res_t   res_nxt;
  logic              s1_go;
  logic              in_take;

  assign s1_go   = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_take = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !s1_v_r || s1_go;

  i2cms_step u_step (
    .st          (st_r),
    .req         (s1_r),
    .phase_ticks (phase_ticks_r),
    .st_nxt      (st_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cms_pkg::PHASE_TICKS_RST;
      s1_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      st_r.scl      <= 1'b1;
      st_r.sda      <= 1'b1;
      st_r.op       <= i2cms_pkg::OP_IDLE;
      st_r.idx      <= 5'd0;
      st_r.cnt      <= 16'd0;
      st_r.tx       <= 8'd0;
      st_r.rx       <= 8'd0;
      st_r.ack      <= 1'b0;
    end else begin
      if (cfg_we) phase_ticks_r <= cfg_wdata;
      if (in_chan.ready) s1_v_r <= in_chan.valid;
      if (s1_go) begin
        st_r    <= st_nxt;
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.command   <= in_chan.command;
      s1_r.tx_byte   <= in_chan.tx_byte;
      s1_r.ack_level <= in_chan.ack_level;
      s1_r.sda_line  <= in_chan.sda_line;
    end
    if (s1_go) out_r <= res_nxt;
  end

  assign out_chan.valid    = out_v_r;
  assign out_chan.scl_out  = out_r.scl_out;
  assign out_chan.sda_out  = out_r.sda_out;
  assign out_chan.busy_res = out_r.busy_res;
  assign out_chan.done_res = out_r.done_res;
  assign out_chan.rx_byte  = out_r.rx_byte;
  assign out_chan.ack_seen = out_r.ack_seen;

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.op == i2cms_pkg::OP_IDLE) |-> (st_r.idx == 5'd0 && st_r.cnt == 16'd0))
    else $error("idle sequencer with nonzero phase or tick count");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.op != i2cms_pkg::OP_IDLE) |-> (st_r.idx < i2cms_pkg::op_len(st_r.op)))
    else $error("phase index beyond operation length");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.done_res) |-> !out_r.busy_res)
    else $error("result flags done and busy together");

  a_state_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_go && out_v_r && !out_chan.ready) |=> $stable(st_r))
    else $error("sequencer state changed while result stalled");

endmodule

`default_nettype wire
